/* src/ffs_pkg.sv */
// Shared types and constants for the flee steering block.
// Depends on nothing; used by ffs_front, ffs_back and flock_fear_steering.
`default_nettype none
package ffs_pkg;

    // default capacity of one list of other-team positions
    localparam int MAX_AGENTS_DEF = 1024;
    // depth of the job queue between front and back
    localparam int QD = 4;
    // width of the neighbour count on the result
    localparam int NCW = 11;
    localparam int RADIUS_W = 23;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [RADIUS_W-1:0] FEAR_RADIUS_RST = 23'd6400;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd512;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEAR_RADIUS = 8'd0,
        CFG_WEIGHT      = 8'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] self_x;
        logic signed [23:0] self_y;
        logic signed [23:0] self_z;
        logic signed [23:0] other_x;
        logic signed [23:0] other_y;
        logic signed [23:0] other_z;
        logic               other_valid;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [23:0] accel_x;
        logic signed [23:0] accel_y;
        logic signed [23:0] accel_z;
        logic [NCW-1:0]     neighbour_count;
        logic               fleeing;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_vec3;

endpackage
`default_nettype wire

/* src/ffs_front.sv */
// Front end: takes one word a cycle unless busy; radius test, accumulate, queue jobs.
// Depends on ffs_pkg.
`default_nettype none
module ffs_front #(
    parameter int MAX_AGENTS = ffs_pkg::MAX_AGENTS_DEF,
    localparam int CW = $clog2(MAX_AGENTS + 1),
    localparam int SW = 24 + CW
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  ffs_pkg::t_in                     i_item,
    input  wire [ffs_pkg::RADIUS_W-1:0]      i_fear_radius,
    output logic                             o_job_valid,
    input  wire                              i_job_pop,
    output ffs_pkg::t_vec3                   o_job_self,
    output logic signed [SW-1:0]             o_job_sum_x,
    output logic signed [SW-1:0]             o_job_sum_y,
    output logic signed [SW-1:0]             o_job_sum_z,
    output logic [CW-1:0]                    o_job_cnt,
    output logic                             o_job_ovf
);
    localparam int QAW = $clog2(ffs_pkg::QD);

    // stage 1: accepted word
    logic         r_s1_v;
    ffs_pkg::t_in r_s1_item;
    // stage 2: squared distance terms
    logic         r_s2_v;
    logic         r_s2_valid;
    logic         r_s2_last;
    ffs_pkg::t_vec3 r_s2_self;
    ffs_pkg::t_vec3 r_s2_other;
    logic [49:0]  r_s2_sq [3];
    logic [45:0]  r_rad2;

    // running list state
    logic signed [SW-1:0] r_sum [3];
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_seen;
    logic                 r_ovf;

    // job queue
    ffs_pkg::t_vec3       r_q_self [ffs_pkg::QD];
    logic signed [SW-1:0] r_q_sum  [ffs_pkg::QD][3];
    logic [CW-1:0]        r_q_cnt  [ffs_pkg::QD];
    logic                 r_q_ovf  [ffs_pkg::QD];
    logic [QAW-1:0]       r_wp, r_rp;
    logic [QAW:0]         r_qcnt;

    logic signed [23:0]   s1_self [3];
    logic signed [23:0]   s1_other [3];
    logic [49:0]          s1_sq [3];
    logic [51:0]          d2;
    logic                 in_rad, full, take;
    logic signed [SW-1:0] n_sum [3];
    logic signed [23:0]   s2_other [3];
    logic [CW-1:0]        n_cnt, n_seen;
    logic                 n_ovf;
    logic                 accept, push;

    // two words may still be in flight when a word is taken
    assign o_busy = (r_qcnt >= (QAW+1)'(ffs_pkg::QD - 2));
    assign accept = i_start && !o_busy;

    // stage 1: magnitudes of the differences, squared
    always_comb begin
        logic signed [24:0] d;
        logic [24:0]        a;
        s1_self[0]  = r_s1_item.self_x;
        s1_self[1]  = r_s1_item.self_y;
        s1_self[2]  = r_s1_item.self_z;
        s1_other[0] = r_s1_item.other_x;
        s1_other[1] = r_s1_item.other_y;
        s1_other[2] = r_s1_item.other_z;
        for (int i = 0; i < 3; i++) begin
            d = 25'(s1_other[i]) - 25'(s1_self[i]);
            a = d[24] ? 25'(-d) : 25'(d);
            s1_sq[i] = 50'(a) * 50'(a);
        end
    end

    // stage 2: radius test, capacity check and accumulation
    always_comb begin
        s2_other[0] = r_s2_other.x;
        s2_other[1] = r_s2_other.y;
        s2_other[2] = r_s2_other.z;
        d2 = 52'(r_s2_sq[0]) + 52'(r_s2_sq[1]) + 52'(r_s2_sq[2]);
        in_rad = (d2 <= 52'(r_rad2));
        full = (r_seen >= CW'(MAX_AGENTS));
        take = r_s2_valid && !full && in_rad;
        n_seen = r_seen + CW'(r_s2_valid && !full);
        n_ovf = r_ovf || (r_s2_valid && full);
        n_cnt = r_cnt + CW'(take);
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = take ? r_sum[i] + SW'(s2_other[i]) : r_sum[i];
        end
    end

    assign push = r_s2_v && r_s2_last;

    // pipeline registers
    always_ff @(posedge i_clk) begin
        r_rad2 <= 46'(i_fear_radius) * 46'(i_fear_radius);
        if (accept) begin
            r_s1_item <= i_item;
        end
        r_s2_valid <= r_s1_item.other_valid;
        r_s2_last  <= r_s1_item.last;
        r_s2_self  <= '{x: r_s1_item.self_x, y: r_s1_item.self_y, z: r_s1_item.self_z};
        r_s2_other <= '{x: r_s1_item.other_x, y: r_s1_item.other_y, z: r_s1_item.other_z};
        for (int i = 0; i < 3; i++) begin
            r_s2_sq[i] <= s1_sq[i];
        end
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    // list state, cleared after each job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            r_cnt  <= '0;
            r_seen <= '0;
            r_ovf  <= 1'b0;
        end else if (r_s2_v) begin
            if (r_s2_last) begin
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                r_cnt  <= '0;
                r_seen <= '0;
                r_ovf  <= 1'b0;
            end else begin
                for (int i = 0; i < 3; i++) r_sum[i] <= n_sum[i];
                r_cnt  <= n_cnt;
                r_seen <= n_seen;
                r_ovf  <= n_ovf;
            end
        end
    end

    // job queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_self[r_wp] <= r_s2_self;
            for (int i = 0; i < 3; i++) r_q_sum[r_wp][i] <= n_sum[i];
            r_q_cnt[r_wp] <= n_cnt;
            r_q_ovf[r_wp] <= n_ovf;
        end
    end

    // job queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_job_pop) r_rp <= r_rp + 1'b1;
            r_qcnt <= r_qcnt + (QAW+1)'(push) - (QAW+1)'(i_job_pop);
        end
    end

    assign o_job_valid = (r_qcnt != '0);
    assign o_job_self  = r_q_self[r_rp];
    assign o_job_sum_x = r_q_sum[r_rp][0];
    assign o_job_sum_y = r_q_sum[r_rp][1];
    assign o_job_sum_z = r_q_sum[r_rp][2];
    assign o_job_cnt   = r_q_cnt[r_rp];
    assign o_job_ovf   = r_q_ovf[r_rp];

endmodule
`default_nettype wire

/* src/ffs_back.sv */
// Back end: flee vector, normalise, integer square root and bit-serial divide.
// Depends on ffs_pkg.
`default_nettype none
module ffs_back #(
    parameter int MAX_AGENTS = ffs_pkg::MAX_AGENTS_DEF,
    localparam int CW = $clog2(MAX_AGENTS + 1),
    localparam int SW = 24 + CW
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_job_valid,
    output logic                         o_job_pop,
    input  ffs_pkg::t_vec3               i_job_self,
    input  wire signed [SW-1:0]          i_job_sum_x,
    input  wire signed [SW-1:0]          i_job_sum_y,
    input  wire signed [SW-1:0]          i_job_sum_z,
    input  wire [CW-1:0]                 i_job_cnt,
    input  wire                          i_job_ovf,
    input  wire [ffs_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                         o_done,
    output ffs_pkg::t_out                o_result
);
    localparam int PW = CW + 25;
    localparam int VW = CW + 26;
    localparam int MW = (VW > 32) ? VW : 32;
    localparam int NCW = ffs_pkg::NCW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PROD, ST_VEC, ST_NORM, ST_SQ, ST_SQE, ST_SQRT, ST_DMUL, ST_DIV
    } t_state;

    t_state               r_state;
    logic signed [23:0]   r_self [3];
    logic signed [SW-1:0] r_sum [3];
    logic [CW-1:0]        r_cnt;
    logic                 r_ovf;
    logic signed [PW-1:0] r_prod [3];
    logic [MW-1:0]        r_m [3];
    logic                 r_neg [3];
    logic [1:0]           r_idx;
    logic [61:0]          r_p;
    logic [63:0]          r_s2;
    logic [63:0]          r_res;
    logic [63:0]          r_bit;
    logic [32:0]          r_r;
    logic [52:0]          r_rem;
    logic [20:0]          r_q;
    logic [4:0]           r_qb;
    logic signed [23:0]   r_acc [3];
    logic                 r_done;
    ffs_pkg::t_out        r_out;

    logic signed [VW-1:0] v [3];
    logic [VW-1:0]        vmag [3];
    logic                 hi_any, lo_all, all_zero;
    logic [63:0]          sq_try;
    logic [19:0]          k;
    logic [50:0]          mk;
    logic [52:0]          num;
    logic [53:0]          den_sh;
    logic [CW+NCW-1:0]    cnt_ext;

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    // flee vector and normalisation tests
    always_comb begin
        hi_any = 1'b0;
        lo_all = 1'b1;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            v[i] = VW'(r_prod[i]) - VW'(r_sum[i]);
            vmag[i] = v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
            if (vmag[i] != '0) all_zero = 1'b0;
            if (r_m[i][MW-1:31] != '0) hi_any = 1'b1;
            if (r_m[i][30]) lo_all = 1'b0;
        end
        sq_try = r_res + r_bit;
        k = {i_weight, 4'b0000};
        mk = 51'(r_m[r_idx[1:0] == 2'd3 ? 2'd0 : r_idx][30:0]) * 51'(k);
        // the root stays in r_res from the end of the square root on
        num = {1'b0, mk, 1'b0} + 53'(r_res[32:0]);
        den_sh = 54'({r_r, 1'b0}) << r_qb;
        cnt_ext = (CW+NCW)'(r_cnt);
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_self[0] <= i_job_self.x;
                        r_self[1] <= i_job_self.y;
                        r_self[2] <= i_job_self.z;
                        r_sum[0] <= i_job_sum_x;
                        r_sum[1] <= i_job_sum_y;
                        r_sum[2] <= i_job_sum_z;
                        r_cnt <= i_job_cnt;
                        r_ovf <= i_job_ovf;
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_prod[i] <= $signed({1'b0, r_cnt}) * r_self[i];
                    end
                    r_state <= ST_VEC;
                end
                ST_VEC: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= MW'(vmag[i]);
                        r_neg[i] <= v[i][VW-1];
                    end
                    // no neighbours or a zero vector: zero acceleration
                    if (r_cnt == '0 || all_zero) begin
                        r_out <= '{accel_x: '0, accel_y: '0, accel_z: '0,
                                   neighbour_count: cnt_ext[NCW-1:0],
                                   fleeing: 1'b0, overflowed: r_ovf};
                        r_done <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // one bit a cycle until the largest lies in [2^30, 2^31)
                    if (hi_any) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (lo_all) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_idx <= 2'd0;
                        r_s2 <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_p <= 62'(r_m[r_idx == 2'd3 ? 2'd0 : r_idx][30:0])
                         * 62'(r_m[r_idx == 2'd3 ? 2'd0 : r_idx][30:0]);
                    if (r_idx != 2'd0) r_s2 <= r_s2 + 64'(r_p);
                    if (r_idx == 2'd2) r_state <= ST_SQE;
                    else r_idx <= r_idx + 2'd1;
                end
                ST_SQE: begin
                    r_s2 <= r_s2 + 64'(r_p);
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    // one result bit a cycle
                    if (r_s2 >= sq_try) begin
                        r_s2 <= r_s2 - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_idx <= 2'd0;
                        r_state <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    if (r_idx == 2'd0) r_r <= r_res[32:0];
                    r_state <= ST_DIV;
                    r_qb <= 5'd20;
                    r_q <= '0;
                    r_rem <= num;
                end
                ST_DIV: begin
                    // restoring divide, quotient below 2^21
                    if ({1'b0, r_rem} >= den_sh) begin
                        r_rem <= r_rem - den_sh[52:0];
                        r_q[r_qb] <= 1'b1;
                    end
                    if (r_qb == 5'd0) begin
                        r_acc[r_idx == 2'd3 ? 2'd0 : r_idx] <=
                            r_neg[r_idx == 2'd3 ? 2'd0 : r_idx]
                            ? -24'(r_q | 21'(({1'b0, r_rem} >= den_sh)))
                            : 24'(r_q | 21'(({1'b0, r_rem} >= den_sh)));
                        if (r_idx == 2'd2) begin
                            r_done <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                            r_state <= ST_DMUL;
                        end
                    end else begin
                        r_qb <= r_qb - 5'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output word: zero path uses r_out, flee path the accumulated components
    logic r_flee_sel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flee_sel <= 1'b0;
        end else if (r_state == ST_VEC) begin
            r_flee_sel <= !(r_cnt == '0 || all_zero);
        end
    end

    assign o_done = r_done;
    always_comb begin
        o_result = r_out;
        if (r_flee_sel) begin
            o_result.accel_x = r_acc[0];
            o_result.accel_y = r_acc[1];
            o_result.accel_z = r_acc[2];
            o_result.neighbour_count = cnt_ext[NCW-1:0];
            o_result.fleeing = 1'b1;
            o_result.overflowed = r_ovf;
        end
    end

endmodule
`default_nettype wire

/* src/flock_fear_steering.sv */
// Flee steering top level: configuration registers, front end, back end.
// Depends on ffs_pkg, ffs_front and ffs_back.
//
// One word (own position plus one other-team position) is taken per cycle while
// busy is low. Words flow through a front end that squares the differences, then
// tests the radius and accumulates; each list end becomes a job in a four-entry
// queue, and busy rises once two jobs wait. The back end works one job at a time:
// the result appears on o_done for a single cycle once the job has left the queue
// and passed the one-bit-a-cycle normalising shift, the 32-step square root and
// three 21-step divides. A list with no neighbours or a zero flee vector skips
// these and returns from the flee-vector step. Results cannot be held off.
`default_nettype none
module flock_fear_steering #(
    parameter int MAX_AGENTS = ffs_pkg::MAX_AGENTS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  ffs_pkg::t_in                    i_item,
    output logic                            o_done,
    output ffs_pkg::t_out                   o_result,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [ffs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [ffs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int CW = $clog2(MAX_AGENTS + 1);
    localparam int SW = 24 + CW;

    logic [ffs_pkg::RADIUS_W-1:0] r_fear_radius;
    logic [ffs_pkg::WEIGHT_W-1:0] r_weight;

    logic                 w_job_valid, w_job_pop, w_job_ovf;
    ffs_pkg::t_vec3       w_job_self;
    logic signed [SW-1:0] w_sum_x, w_sum_y, w_sum_z;
    logic [CW-1:0]        w_job_cnt;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fear_radius <= ffs_pkg::FEAR_RADIUS_RST;
            r_weight <= ffs_pkg::WEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ffs_pkg::CFG_FEAR_RADIUS) begin
                r_fear_radius <= i_cfg_data[ffs_pkg::RADIUS_W-1:0];
            end
            if (i_cfg_index == ffs_pkg::CFG_WEIGHT) begin
                r_weight <= i_cfg_data[ffs_pkg::WEIGHT_W-1:0];
            end
        end
    end

    ffs_front #(.MAX_AGENTS(MAX_AGENTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_item       (i_item),
        .i_fear_radius(r_fear_radius),
        .o_job_valid  (w_job_valid),
        .i_job_pop    (w_job_pop),
        .o_job_self   (w_job_self),
        .o_job_sum_x  (w_sum_x),
        .o_job_sum_y  (w_sum_y),
        .o_job_sum_z  (w_sum_z),
        .o_job_cnt    (w_job_cnt),
        .o_job_ovf    (w_job_ovf)
    );

    ffs_back #(.MAX_AGENTS(MAX_AGENTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .o_job_pop  (w_job_pop),
        .i_job_self (w_job_self),
        .i_job_sum_x(w_sum_x),
        .i_job_sum_y(w_sum_y),
        .i_job_sum_z(w_sum_z),
        .i_job_cnt  (w_job_cnt),
        .i_job_ovf  (w_job_ovf),
        .i_weight   (r_weight),
        .o_done     (o_done),
        .o_result   (o_result)
    );

`ifndef NO_ASSERTIONS
    // the back end only takes a job that the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> w_job_valid) else $error("job taken from empty queue");

    // a result word never repeats on the next cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    // no flee direction means zero acceleration
    a_zero_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.fleeing) |-> (o_result.accel_x == '0 &&
        o_result.accel_y == '0 && o_result.accel_z == '0))
        else $error("acceleration without flee direction");
`endif

endmodule
`default_nettype wire

/* bench/flock_fear_steering_chk.sv */
// Checker for the flee steering block: watches the item, config and result channels,
// predicts every result and compares the whole word, listing fields on a mismatch.
// Depends on ffs_pkg.
`default_nettype none
module flock_fear_steering_chk (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_busy,
    input  ffs_pkg::t_in  i_item,
    input  wire           i_done,
    input  ffs_pkg::t_out i_result,
    input  wire           i_cfg_valid,
    input  wire           i_cfg_ready,
    input  wire [ffs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [ffs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int            o_pending,
    output int            o_errors
);
    import ffs_pkg::*;

    // model copy of registers and list state
    logic [RADIUS_W-1:0] radius;
    logic [WEIGHT_W-1:0] wgt;
    longint              acc_x, acc_y, acc_z;
    int                  n_inside, n_seen;
    bit                  ovf;
    t_out                flee_q[$];

    assign o_pending = flee_q.size();

    function automatic bit [63:0] root_floor(bit [63:0] n);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // flee vector, normalised and scaled by the weight
    function automatic t_out flee_word(longint sx, longint sy, longint sz);
        t_out      w;
        longint    v[3];
        bit [63:0] m[3], mx, r, k, q;
        longint    a[3];
        w = '0;
        a = '{0, 0, 0};
        if (n_inside != 0) begin
            v[0] = n_inside * sx - acc_x;
            v[1] = n_inside * sy - acc_y;
            v[2] = n_inside * sz - acc_z;
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = v[i] < 0 ? -v[i] : v[i];
                if (m[i] > mx) mx = m[i];
            end
            if (mx != 0) begin
                w.fleeing = 1'b1;
                while (mx >= (64'd1 << 31)) begin
                    mx = mx >> 1;
                    for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
                end
                while (mx < (64'd1 << 30)) begin
                    mx = mx << 1;
                    for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
                end
                r = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                k = 16 * wgt;
                for (int i = 0; i < 3; i++) begin
                    q = (2 * m[i] * k + r) / (2 * r);
                    a[i] = v[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
        w.accel_x = a[0][23:0];
        w.accel_y = a[1][23:0];
        w.accel_z = a[2][23:0];
        w.neighbour_count = n_inside[NCW-1:0];
        w.overflowed = ovf;
        return w;
    endfunction

    // accept words, config writes and results at the rising edge
    always @(posedge i_clk) begin
        longint    sx, sy, sz, ox, oy, oz, dx, dy, dz;
        bit [63:0] d2;
        t_out      exp_w;
        if (!i_rst_n) begin
            radius <= FEAR_RADIUS_RST;
            wgt <= WEIGHT_RST;
            acc_x = 0; acc_y = 0; acc_z = 0;
            n_inside = 0; n_seen = 0; ovf = 0;
            flee_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FEAR_RADIUS) radius <= i_cfg_data[RADIUS_W-1:0];
                else if (i_cfg_index == CFG_WEIGHT) wgt <= i_cfg_data[WEIGHT_W-1:0];
            end
            if (i_done) begin
                if (flee_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = flee_q.pop_front();
                    if (exp_w !== i_result) begin
                        $display("%0t: mismatch expected ax=%0d ay=%0d az=%0d n=%0d f=%0b o=%0b",
                                 $time, exp_w.accel_x, exp_w.accel_y, exp_w.accel_z,
                                 exp_w.neighbour_count, exp_w.fleeing, exp_w.overflowed);
                        $display("%0t:          actual   ax=%0d ay=%0d az=%0d n=%0d f=%0b o=%0b",
                                 $time, i_result.accel_x, i_result.accel_y, i_result.accel_z,
                                 i_result.neighbour_count, i_result.fleeing,
                                 i_result.overflowed);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                sx = i_item.self_x; sy = i_item.self_y; sz = i_item.self_z;
                ox = i_item.other_x; oy = i_item.other_y; oz = i_item.other_z;
                if (i_item.other_valid) begin
                    if (n_seen >= MAX_AGENTS_DEF) begin
                        ovf = 1;
                    end else begin
                        dx = ox - sx; dy = oy - sy; dz = oz - sz;
                        d2 = dx * dx + dy * dy + dz * dz;
                        n_seen++;
                        if (d2 <= 64'(radius) * 64'(radius)) begin
                            acc_x += ox; acc_y += oy; acc_z += oz;
                            n_inside++;
                        end
                    end
                end
                if (i_item.last) begin
                    flee_q.push_back(flee_word(sx, sy, sz));
                    acc_x = 0; acc_y = 0; acc_z = 0;
                    n_inside = 0; n_seen = 0; ovf = 0;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* bench/flock_fear_steering_tb.sv */
// Testbench top for flock_fear_steering: clock, reset, config phases and word stimulus.
// Depends on ffs_pkg, flock_fear_steering and flock_fear_steering_chk.
`default_nettype none
module flock_fear_steering_tb;
    import ffs_pkg::*;

    logic i_clk = 0, i_rst_n = 0;
    logic start = 0;
    wire  busy;
    t_in  i_item = '0;
    wire  o_done;
    t_out o_result;
    logic i_cfg_valid = 0;
    wire  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int   pending, errors;
    bit   gaps_on = 1;
    int   words_sent = 0;
    int   cur_radius = 6400;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    flock_fear_steering DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    flock_fear_steering_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_item(i_item),
        .i_done(o_done), .i_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        #50_000_000;
        $display("[flock_fear_steering] ERROR");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance or after a gap
    task automatic send_word(t_in w);
        start <= 1'b1;
        i_item <= w;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        words_sent++;
        if (gaps_on && $urandom_range(0, 99) < 37) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // wait for all results, then let the back end drain
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in mk(int sx, int sy, int sz, int ox, int oy, int oz,
                               bit vld, bit lst);
        t_in w;
        w.self_x = sx[23:0]; w.self_y = sy[23:0]; w.self_z = sz[23:0];
        w.other_x = ox[23:0]; w.other_y = oy[23:0]; w.other_z = oz[23:0];
        w.other_valid = vld;
        w.last = lst;
        return w;
    endfunction

    function automatic int near(int c, int span);
        return c + $urandom_range(0, 2 * span) - span;
    endfunction

    // one list: mostly in-range neighbours, some noise and invalid words
    task automatic random_list(int len);
        int sx, sy, sz, span;
        t_in w;
        bit [159:0] rnd;
        sx = $urandom_range(0, 2_000_000) - 1_000_000;
        sy = $urandom_range(0, 2_000_000) - 1_000_000;
        sz = $urandom_range(0, 2_000_000) - 1_000_000;
        span = cur_radius / 2 + 1;
        if (span > 3_000_000) span = 3_000_000;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                sx = near(sx, span); sy = near(sy, span); sz = near(sz, span);
            end
            if ($urandom_range(0, 9) == 0) begin
                rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
                w = rnd[$bits(t_in)-1:0];
            end else
                w = mk(sx, sy, sz, near(sx, span), near(sy, span), near(sz, span),
                       1'b1, 1'b0);
            if ($urandom_range(0, 9) == 0) w.other_valid = 1'b0;
            w.last = (i == len - 1);
            send_word(w);
        end
    endtask

    localparam int MAXP = 8388607;
    localparam int MINN = -8388608;

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes at reset config and at the largest radius
        send_word(mk(0, 0, 0, 100, -50, 30, 1, 0));
        send_word(mk(0, 0, 0, -60, 20, 10, 1, 1));
        send_word(mk(0, 0, 0, 0, 0, 0, 0, 1));             // empty list
        send_word(mk(5, 5, 5, 5, 5, 5, 1, 1));             // zero flee vector
        send_word(mk(0, 0, 0, 90000, 0, 0, 1, 1));         // nobody inside
        send_word(mk(10, 10, 10, 20, 20, 20, 1, 0));
        send_word(mk(-10, 40, 10, 0, 0, 0, 0, 1));         // last word invalid, self moved
        drain();
        write_reg(CFG_FEAR_RADIUS, MAXP);
        write_reg(CFG_WEIGHT, 16'hFFFF);
        send_word(mk(MAXP, MAXP, MAXP, MINN, MINN, MINN, 1, 1));
        send_word(mk(MINN, MINN, MINN, MINN, MINN, MINN, 1, 1));
        send_word(mk(MINN, MAXP, MINN, MINN + 1000, MAXP, 0, 1, 0));
        send_word(mk(MAXP, MINN, MAXP, 0, MINN, MAXP, 1, 1));
        send_word(mk(MINN, 0, MAXP, MAXP, -1, 1, 1, 1));
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin cur_radius = 6400; write_reg(CFG_FEAR_RADIUS, 6400);
                         write_reg(CFG_WEIGHT, 512); end
                1: begin cur_radius = 0; write_reg(CFG_FEAR_RADIUS, 0);
                         write_reg(CFG_WEIGHT, 0); end
                2: begin cur_radius = MAXP; write_reg(CFG_FEAR_RADIUS, MAXP);
                         write_reg(CFG_WEIGHT, 16'hFFFF); end
                default: begin
                    cur_radius = $urandom_range(1, 200_000);
                    write_reg(CFG_FEAR_RADIUS, cur_radius);
                    write_reg(CFG_WEIGHT, $urandom_range(0, 65535));
                end
            endcase
            gaps_on = (ph != 3);
            repeat (24) begin
                random_list($urandom_range(1, 8));
                if ($urandom_range(0, 29) == 0) begin
                    // hold off until every result is back
                    start <= 1'b0;
                    @(negedge i_clk);
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        // one list past capacity
        gaps_on = 0;
        write_reg(CFG_FEAR_RADIUS, MAXP);
        for (int i = 0; i < 1030; i++)
            send_word(mk(100, 200, 300, $urandom_range(0, 4000), 7, -9, 1, i == 1029));
        drain();

        if (errors == 0) begin
            $display("[flock_fear_steering] OK");
        end else begin
            $display("[flock_fear_steering] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
